// ===== hw/rtl/esp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// esp_pkg: shared types and constants for the encoder setpoint panel
// Holds the quadrature step decode, key codes, register indexes and the
// per-encoder state record used by the top level and the encoder unit.
// ----------------------------------------------------------------------------
package esp_pkg;

	// Field widths.
	localparam int unsigned VoltW = 16;
	localparam int unsigned CurrW = 12;
	localparam int unsigned StepW = 10;
	localparam int unsigned CfgW  = 16;
	localparam int unsigned IdxW  = 3;

	// Configuration register indexes.
	localparam logic [IdxW-1:0] REG_VOLTAGE_LIMIT = 3'd0;
	localparam logic [IdxW-1:0] REG_CURRENT_LIMIT = 3'd1;
	localparam logic [IdxW-1:0] REG_VOLTAGE_STEP  = 3'd2;
	localparam logic [IdxW-1:0] REG_CURRENT_STEP  = 3'd3;
	localparam logic [IdxW-1:0] REG_PRESET_ONE_MV = 3'd4;
	localparam logic [IdxW-1:0] REG_PRESET_ONE_MA = 3'd5;
	localparam logic [IdxW-1:0] REG_PRESET_TWO_MV = 3'd6;
	localparam logic [IdxW-1:0] REG_PRESET_TWO_MA = 3'd7;

	// Touch key codes.
	localparam logic [2:0] KEY_MEM_ONE = 3'd1;
	localparam logic [2:0] KEY_MEM_TWO = 3'd2;
	localparam logic [2:0] KEY_OUTPUT  = 3'd4;

	// Memory light patterns (bit 0 memory one, bit 1 memory two).
	localparam logic [1:0] LIGHTS_OFF = 2'b00;
	localparam logic [1:0] LIGHTS_ONE = 2'b01;
	localparam logic [1:0] LIGHTS_TWO = 2'b10;

	// Direction of one decoded quadrature count, as seen by the setpoint.
	typedef enum logic [1:0] {
		STEP_NONE = 2'b00,
		STEP_UP   = 2'b01,
		STEP_DOWN = 2'b10
	} step_t;

	// Per-encoder tracking state.
	typedef struct packed {
		logic [2:0] prev;
		logic [3:0] hist;
	} enc_state_t;

	// Decode a 4-bit transition history into a setpoint direction.
	function automatic step_t step_lookup(input logic [3:0] hist);
		step_t s;
		case (hist)
			4'd1, 4'd7, 4'd8, 4'd14:  s = STEP_UP;
			4'd2, 4'd4, 4'd11, 4'd13: s = STEP_DOWN;
			default:                  s = STEP_NONE;
		endcase
		return s;
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/encoder_setpoint_panel.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// encoder_setpoint_panel: bench supply front panel controller
// Turns encoder samples and touch-key codes into setpoints and panel state.
// ----------------------------------------------------------------------------
// Usage:
// Each transfer on the slave stream carries one panel sample: both encoders'
// pins and, flagged in tuser, whether the encoder sample and the key code
// are to be processed. Every sample produces exactly one result transfer on
// the master stream with the setpoints, output enable, memory lights and
// the two converter write strobes.
// A sample accepted into the input register moves on into the result
// register, where its result is held until taken. One sample is accepted
// per cycle while the receiver keeps taking results; the panel state is
// updated as each sample moves from the input register into the result
// register.
// When the receiver stalls, the result register holds and the input
// register still takes one more sample; s_tready then drops until the
// result is taken.
// Reset clears the panel state (current setpoint 1500 mA, voltage zero,
// output off, lights off) and loads default register values. The user must
// write registers (cfg_wen/cfg_index/cfg_wdata) while idle; not enforced.
// ----------------------------------------------------------------------------
module encoder_setpoint_panel (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// Configuration write port.
	input  wire logic                        cfg_wen,
	input  wire logic [esp_pkg::IdxW-1:0]    cfg_index,
	input  wire logic [esp_pkg::CfgW-1:0]    cfg_wdata,
	// Sample stream.
	input  wire logic                        s_tvalid,
	output logic                             s_tready,
	// [2:0] voltage_encoder_bits, [5:3] current_encoder_bits, [8:6] key_code,
	// [15:9] zero
	input  wire logic [15:0]                 s_tdata,
	// [0] encoder_sample_valid, [1] key_valid
	input  wire logic [1:0]                  s_tuser,
	// Result stream.
	output logic                             m_tvalid,
	input  wire logic                        m_tready,
	// [15:0] voltage_setpoint_mv, [27:16] current_setpoint_ma,
	// [28] output_enabled, [29] memory_one_lit, [30] memory_two_lit,
	// [31] voltage_write, [32] current_write, [39:33] zero
	output logic [39:0]                      m_tdata
);
	import esp_pkg::*;

	// Configuration registers.
	logic [VoltW-1:0] v_limit_q, v_preset1_q, v_preset2_q;
	logic [CurrW-1:0] c_limit_q, c_preset1_q, c_preset2_q;
	logic [StepW-1:0] v_incr_q, c_incr_q;

	// Panel state.
	enc_state_t       v_enc_q, c_enc_q;
	logic [VoltW-1:0] v_target_q;
	logic [CurrW-1:0] c_target_q;
	logic             out_on_q;
	logic [1:0]       lights_q;

	// Input register.
	logic             valid_s1;
	logic [15:0]      data_s1;
	logic [1:0]       user_s1;

	logic             advance;

	// Next-state signals.
	enc_state_t       v_enc_nx, c_enc_nx;
	logic [VoltW-1:0] v_enc_tgt, c_enc_tgt_w;
	logic             v_moved, c_moved;
	logic [VoltW-1:0] v_target_nx;
	logic [CurrW-1:0] c_target_nx;
	logic             out_on_nx;
	logic [1:0]       lights_nx;
	logic             v_write, c_write;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_limit_q   <= VoltW'(15000);
			c_limit_q   <= CurrW'(1500);
			v_incr_q    <= StepW'(50);
			c_incr_q    <= StepW'(50);
			v_preset1_q <= VoltW'(3300);
			c_preset1_q <= CurrW'(500);
			v_preset2_q <= VoltW'(5000);
			c_preset2_q <= CurrW'(500);
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_VOLTAGE_LIMIT: v_limit_q   <= cfg_wdata[VoltW-1:0];
				REG_CURRENT_LIMIT: c_limit_q   <= cfg_wdata[CurrW-1:0];
				REG_VOLTAGE_STEP:  v_incr_q    <= cfg_wdata[StepW-1:0];
				REG_CURRENT_STEP:  c_incr_q    <= cfg_wdata[StepW-1:0];
				REG_PRESET_ONE_MV: v_preset1_q <= cfg_wdata[VoltW-1:0];
				REG_PRESET_ONE_MA: c_preset1_q <= cfg_wdata[CurrW-1:0];
				REG_PRESET_TWO_MV: v_preset2_q <= cfg_wdata[VoltW-1:0];
				REG_PRESET_TWO_MA: c_preset2_q <= cfg_wdata[CurrW-1:0];
				default: begin
				end
			endcase
		end
	end

	// Handshake: the input register moves on whenever the result register
	// is empty or its result is being taken.
	assign advance  = !m_tvalid || m_tready;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			data_s1 <= s_tdata;
			user_s1 <= s_tuser;
		end
	end

	// Encoder channels.
	esp_encoder u_v_enc (
		.bits        (data_s1[2:0]),
		.state       (v_enc_q),
		.target      (v_target_q),
		.incr        (v_incr_q),
		.limit       (v_limit_q),
		.state_next  (v_enc_nx),
		.target_next (v_enc_tgt),
		.moved       (v_moved)
	);

	esp_encoder u_c_enc (
		.bits        (data_s1[5:3]),
		.state       (c_enc_q),
		.target      ({{(VoltW - CurrW){1'b0}}, c_target_q}),
		.incr        (c_incr_q),
		.limit       ({{(VoltW - CurrW){1'b0}}, c_limit_q}),
		.state_next  (c_enc_nx),
		.target_next (c_enc_tgt_w),
		.moved       (c_moved)
	);

	// Combine encoder moves with the touch key, the key acting last.
	always_comb begin
		v_target_nx = v_target_q;
		c_target_nx = c_target_q;
		out_on_nx   = out_on_q;
		lights_nx   = lights_q;
		v_write     = 1'b0;
		c_write     = 1'b0;
		if (user_s1[0]) begin
			if (v_moved) begin
				v_target_nx = v_enc_tgt;
				v_write     = 1'b1;
			end
			if (c_moved) begin
				c_target_nx = c_enc_tgt_w[CurrW-1:0];
				c_write     = 1'b1;
				lights_nx   = LIGHTS_OFF;
			end
		end
		if (user_s1[1]) begin
			case (data_s1[8:6])
				KEY_MEM_ONE: begin
					v_target_nx = v_preset1_q;
					c_target_nx = c_preset1_q;
					lights_nx   = LIGHTS_ONE;
					v_write     = 1'b1;
					c_write     = 1'b1;
				end
				KEY_MEM_TWO: begin
					v_target_nx = v_preset2_q;
					c_target_nx = c_preset2_q;
					lights_nx   = LIGHTS_TWO;
					v_write     = 1'b1;
					c_write     = 1'b1;
				end
				KEY_OUTPUT: begin
					out_on_nx = !out_on_q;
					if (!out_on_q) begin
						v_write = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Panel state update, once per sample leaving the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_enc_q    <= '0;
			c_enc_q    <= '0;
			v_target_q <= '0;
			c_target_q <= CurrW'(1500);
			out_on_q   <= 1'b0;
			lights_q   <= LIGHTS_OFF;
		end else if (valid_s1 && advance) begin
			if (user_s1[0]) begin
				v_enc_q <= v_enc_nx;
				c_enc_q <= c_enc_nx;
			end
			v_target_q <= v_target_nx;
			c_target_q <= c_target_nx;
			out_on_q   <= out_on_nx;
			lights_q   <= lights_nx;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (advance) begin
			m_tvalid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			m_tdata <= {7'b0, c_write, v_write, lights_nx[1], lights_nx[0], out_on_nx,
				c_target_nx, v_target_nx};
		end
	end

	// A sample leaving the input register always lands in the result register.
	a_s1_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && advance) |=> m_tvalid)
		else $error("sample lost between input and result register");

	// Both memory lights are never lit together.
	a_lights: assert property (@(posedge clk) disable iff (!arst_n)
		lights_q != 2'b11)
		else $error("both memory lights lit");

	// Back-pressure only with a full input register and a stalled result.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && m_tvalid && !m_tready))
		else $error("input stalled without cause");

	// Panel state holds while the result is stalled.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> ($stable(v_target_q) && $stable(c_target_q)
			&& $stable(lights_q) && $stable(out_on_q)))
		else $error("panel state changed during a stall");

endmodule
`default_nettype wire

// ===== hw/rtl/esp_encoder.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// esp_encoder: one quadrature encoder channel
// Tracks the sample history, decodes a count and moves the setpoint by one
// increment, clamped between zero and the limit.
// ----------------------------------------------------------------------------
module esp_encoder (
	input  wire logic [2:0]                    bits,
	input  wire esp_pkg::enc_state_t           state,
	input  wire logic [esp_pkg::VoltW-1:0]     target,
	input  wire logic [esp_pkg::StepW-1:0]     incr,
	input  wire logic [esp_pkg::VoltW-1:0]     limit,
	output esp_pkg::enc_state_t                state_next,
	output logic [esp_pkg::VoltW-1:0]          target_next,
	output logic                               moved
);
	import esp_pkg::*;

	logic          changed;
	logic [3:0]    hist_new;
	step_t         step;
	logic [VoltW:0] sum;
	logic [VoltW:0] diff;

	// History shift and step decode.
	assign changed  = (bits != state.prev);
	assign hist_new = {state.hist[1:0], bits[1:0]};
	assign step     = step_lookup(hist_new);

	assign sum  = {1'b0, target} + {{(VoltW + 1 - StepW){1'b0}}, incr};
	assign diff = {1'b0, target} - {{(VoltW + 1 - StepW){1'b0}}, incr};

	// Next state and clamped setpoint.
	always_comb begin
		state_next  = state;
		target_next = target;
		moved       = 1'b0;
		if (changed) begin
			state_next.prev = bits;
			state_next.hist = hist_new;
			case (step)
				STEP_UP: begin
					moved = 1'b1;
					if (sum > {1'b0, limit}) begin
						target_next = limit;
					end else begin
						target_next = sum[VoltW-1:0];
					end
				end
				STEP_DOWN: begin
					moved = 1'b1;
					if (diff[VoltW]) begin
						target_next = '0;
					end else if (diff > {1'b0, limit}) begin
						target_next = limit;
					end else begin
						target_next = diff[VoltW-1:0];
					end
				end
				default: begin
					moved = 1'b0;
				end
			endcase
		end
	end

endmodule
`default_nettype wire
